[hw/rtl/deq_pkg.sv]
// Shared types and constants of the double-ended queue.
// Holds the operation and status codes and the controller/datapath interface structs.
// Depends on nothing.
`default_nettype none

package deq_pkg;

    // Operation codes carried in the input word's tuser.
    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_REAR  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_REAR   = 3'd3;
    localparam logic [2:0] FN_DUMP_FWD   = 3'd4;
    localparam logic [2:0] FN_DUMP_BWD   = 3'd5;

    // Status codes carried in the output word's tuser.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Source of the next output word.
    typedef enum logic [1:0] {
        OS_OK    = 2'd0,
        OS_FULL  = 2'd1,
        OS_EMPTY = 2'd2,
        OS_DATA  = 2'd3
    } t_out_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     wr_front;
        logic     wr_rear;
        logic     rd_front;
        logic     rd_rear;
        logic     rd_dump;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] func;
        logic       full;
        logic       empty;
        logic       dump_last;
        logic       out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit values in a ring buffer of DEPTH entries.
// A push writes the ring buffer unless full and loads its status word; a pop reads the
// memory and then loads the output register. New input words are taken only when idle.
// A dump of a nonempty queue gives its words one by one (memory read, then output
// load) and holds the input until it ends; stalls on the result side hold it longer.
// Synchronous active-low reset empties the queue; the memory is not cleared.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input words.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] value
    input  wire logic [2:0]  s_axis_tuser,  // [2:0] func
    // Result words.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] result_value
    output logic [1:0]       m_axis_tuser,  // [1:0] status
    output logic             m_axis_tlast
);
    import deq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller decodes the captured operation and steps the datapath:
    // pushes write the ring buffer directly, pops and dumps read it through a
    // registered port and then load the output register.
    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the entries, the head index, the occupancy, the
    // dump counter and the output register that decouples the result side.
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_func       (s_axis_tuser),
        .i_value      (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/deq_dp.sv]
// Datapath of the double-ended queue: ring buffer memory, head and occupancy
// registers, dump counter and the output register. Depends on deq_pkg.
`default_nettype none

module deq_dp #(
    parameter int DEPTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire deq_pkg::t_dp_cmd i_cmd,
    output deq_pkg::t_dp_sts     o_sts,
    input  wire logic [2:0]      i_func,
    input  wire logic [31:0]     i_value,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [31:0]          o_out_data,
    output logic [1:0]           o_out_status,
    output logic                 o_out_last
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rdata;
    logic [2:0]    r_func;
    logic [31:0]   r_value;
    logic [AW-1:0] r_head;
    logic [OW-1:0] r_occ;
    logic [AW-1:0] r_cnt;
    logic          r_ovalid;
    logic [31:0]   r_odata;
    logic [1:0]    r_ostatus;
    logic          r_olast;

    logic [OW-1:0] w_occ_m1;
    logic [AW-1:0] w_head_dec;
    logic [AW-1:0] w_head_inc;
    logic [AW-1:0] w_dump_off;
    logic [AW-1:0] w_rear_wr;
    logic [AW-1:0] w_rear_rd;
    logic [AW-1:0] w_dump_addr;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_out_free;

    // Sum of two indexes below DEPTH, folded back into the ring.
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        return (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
    endfunction

    assign w_occ_m1    = r_occ - OW'(1);
    assign w_head_dec  = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign w_head_inc  = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign w_dump_off  = (r_func == FN_DUMP_FWD) ? r_cnt : AW'(w_occ_m1) - r_cnt;
    assign w_rear_wr   = wrap(SW'(r_head) + SW'(r_occ));
    assign w_rear_rd   = wrap(SW'(r_head) + SW'(w_occ_m1));
    assign w_dump_addr = wrap(SW'(r_head) + SW'(w_dump_off));
    assign w_wr_addr   = i_cmd.wr_front ? w_head_dec : w_rear_wr;
    assign w_out_free  = !r_ovalid || i_out_ready;

    always_comb begin
        w_rd_addr = w_dump_addr;
        if (i_cmd.rd_front) begin
            w_rd_addr = r_head;
        end else if (i_cmd.rd_rear) begin
            w_rd_addr = w_rear_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_front || i_cmd.wr_rear) begin
            r_mem[w_wr_addr] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_front || i_cmd.rd_rear || i_cmd.rd_dump) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.wr_front) begin
                r_head <= w_head_dec;
                r_occ  <= r_occ + OW'(1);
            end else if (i_cmd.wr_rear) begin
                r_occ  <= r_occ + OW'(1);
            end else if (i_cmd.rd_front) begin
                r_head <= w_head_inc;
                r_occ  <= w_occ_m1;
            end else if (i_cmd.rd_rear) begin
                r_occ  <= w_occ_m1;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_olast <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OS_DATA: begin
                    r_odata   <= r_rdata;
                    r_ostatus <= ST_OK;
                end
                OS_FULL: begin
                    r_odata   <= '0;
                    r_ostatus <= ST_FULL;
                end
                OS_EMPTY: begin
                    r_odata   <= '0;
                    r_ostatus <= ST_EMPTY;
                end
                default: begin
                    r_odata   <= '0;
                    r_ostatus <= ST_OK;
                end
            endcase
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.full      = (r_occ == FULL_OCC);
    assign o_sts.empty     = (r_occ == '0);
    assign o_sts.dump_last = (OW'(r_cnt) == w_occ_m1);
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid  = r_ovalid;
    assign o_out_data   = r_odata;
    assign o_out_status = r_ostatus;
    assign o_out_last   = r_olast;

endmodule

`default_nettype wire

[hw/rtl/deq_ctrl.sv]
// Controller state machine of the double-ended queue.
// Sequences each operation through the datapath. Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire deq_pkg::t_dp_sts i_sts,
    output deq_pkg::t_dp_cmd      o_cmd
);
    import deq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_is_pop;

    assign w_is_pop = (i_sts.func == FN_POP_FRONT) || (i_sts.func == FN_POP_REAR);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // An accepted word leaves the output register empty next cycle.
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_sts.func) inside
                    FN_PUSH_FRONT, FN_PUSH_REAR: begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_last = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.out_sel = OS_FULL;
                        end else begin
                            o_cmd.out_sel  = OS_OK;
                            o_cmd.wr_front = (i_sts.func == FN_PUSH_FRONT);
                            o_cmd.wr_rear  = (i_sts.func == FN_PUSH_REAR);
                        end
                    end
                    FN_POP_FRONT, FN_POP_REAR: begin
                        if (i_sts.empty) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            o_cmd.out_sel  = OS_EMPTY;
                        end else begin
                            o_cmd.rd_front = (i_sts.func == FN_POP_FRONT);
                            o_cmd.rd_rear  = (i_sts.func == FN_POP_REAR);
                            n_state        = S_EMIT;
                        end
                    end
                    FN_DUMP_FWD, FN_DUMP_BWD: begin
                        if (i_sts.empty) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            o_cmd.out_sel  = OS_EMPTY;
                        end else begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_dump = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OS_DATA;
                    if (w_is_pop || i_sts.dump_last) begin
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[dv/double_ended_queue_check.sv]
`timescale 1ns / 1ps
// Checker for the double-ended queue: watches both stream channels and tracks its own ring.
// Each result word is compared with the next expected word. Depends on deq_pkg.

module double_ended_queue_check
    import deq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] value
    input  logic [2:0]  i_s_tuser,  // [2:0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,  // [31:0] result_value
    input  logic [1:0]  i_m_tuser,  // [1:0] status
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } t_deq_word;

    logic [31:0] ring [DEPTH];
    int          ring_head;
    int          ring_count;
    t_deq_word   awaited_words[$];

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic await_word(input logic [31:0] value, input logic [1:0] status,
                              input logic last);
        t_deq_word w;
        w.value  = value;
        w.status = status;
        w.last   = last;
        awaited_words.push_back(w);
    endtask

    // Applies one operation to the tracked ring and queues the words it must produce.
    task automatic predict_deque_op(input logic [2:0] fn, input logic [31:0] val);
        int k;
        int off;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_REAR: begin
                if (ring_count >= DEPTH) begin
                    await_word(32'd0, ST_FULL, 1'b1);
                end else begin
                    if (fn == FN_PUSH_FRONT) begin
                        ring_head = (ring_head + DEPTH - 1) % DEPTH;
                        ring[ring_head] = val;
                    end else begin
                        ring[(ring_head + ring_count) % DEPTH] = val;
                    end
                    ring_count++;
                    await_word(32'd0, ST_OK, 1'b1);
                end
            end
            FN_POP_FRONT, FN_POP_REAR, FN_DUMP_FWD, FN_DUMP_BWD: begin
                if (ring_count == 0) begin
                    await_word(32'd0, ST_EMPTY, 1'b1);
                end else if (fn == FN_POP_FRONT) begin
                    await_word(ring[ring_head], ST_OK, 1'b1);
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end else if (fn == FN_POP_REAR) begin
                    ring_count--;
                    await_word(ring[(ring_head + ring_count) % DEPTH], ST_OK, 1'b1);
                end else begin
                    for (k = 0; k < ring_count; k++) begin
                        off = (fn == FN_DUMP_FWD) ? k : ring_count - 1 - k;
                        await_word(ring[(ring_head + off) % DEPTH], ST_OK,
                                   k == ring_count - 1);
                    end
                end
            end
            default: ;  // Unused codes leave the queue alone and produce nothing.
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_deq_word want;
        if (!i_rst_n) begin
            ring_head    = 0;
            ring_count   = 0;
            o_fail_count = 0;
            awaited_words.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_deque_op(i_s_tuser, i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word value %0d status %0d last %0b",
                                              $signed(i_m_tdata), i_m_tuser, i_m_tlast));
                end else begin
                    want = awaited_words.pop_front();
                    if (i_m_tdata !== want.value) begin
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  $signed(i_m_tdata), $signed(want.value)));
                    end
                    if (i_m_tuser !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_m_tuser, want.status));
                    end
                    if (i_m_tlast !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  i_m_tlast, want.last));
                    end
                end
            end
        end
        o_pending = awaited_words.size();
    end

endmodule

[dv/double_ended_queue_test.sv]
`timescale 1ns / 1ps
// Top of the double-ended queue testbench: clock, reset, stimulus and the final verdict.
// Depends on deq_pkg, double_ended_queue and double_ended_queue_check.

module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_OPS  = 75;
    localparam int DRAIN_WAIT  = 16;

    // The two function codes that the block must ignore.
    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;  // [31:0] value
    logic [2:0]  s_axis_tuser  = 3'd0;   // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] result_value
    logic [1:0]  m_axis_tuser;           // [1:0] status
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int cycles    = 0;
    int level     = 0;  // Our own count of stored values, used only to shape sequences.
    int sent      = 0;  // Words with a defined function code that the block has taken.
    bit tx_calm   = 1'b0;
    bit rx_calm   = 1'b0;
    int rx_stall  = 0;
    logic rx_took = 1'b0;

    always #2 i_clk = ~i_clk;

    double_ended_queue #(.DEPTH(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    double_ended_queue_check #(.DEPTH(DEPTH)) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Hard stop in case the block hangs or loses words.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL double_ended_queue");
            $finish;
        end
    end

    // Result side. After each accepted word a fresh stall length is drawn, and
    // tready is held low for the drawn stall before it rises again. In calm
    // stretches the stall is zero so that words can leave back to back.
    always @(posedge i_clk) begin
        rx_took <= m_axis_tvalid && m_axis_tready;
    end

    always @(negedge i_clk) begin
        if (rx_took) begin
            rx_stall = rx_calm ? 0 : $urandom_range(0, 8);
        end
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Values lean toward the extremes of the signed range, zero and minus one; the rest is uniform.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mix of operations for the free-running stretches. Pushes slightly
    // outweigh pops so the queue wanders through all fill levels.
    function automatic logic [2:0] pick_mixed_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)      return FN_PUSH_FRONT;
        else if (r < 40) return FN_PUSH_REAR;
        else if (r < 57) return FN_POP_FRONT;
        else if (r < 74) return FN_POP_REAR;
        else if (r < 83) return FN_DUMP_FWD;
        else if (r < 92) return FN_DUMP_BWD;
        else if (r < 96) return FN_SPARE_LO;
        else             return FN_SPARE_HI;
    endfunction

    // Offers one word on the input channel. It is entered at a falling edge
    // and returns at the falling edge after the word was taken. When no gap is
    // drawn, tvalid simply stays high and only the payload changes.
    task automatic send_word(input logic [2:0] fn, input logic [31:0] val);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_REAR: if (level < DEPTH) level++;
            FN_POP_FRONT, FN_POP_REAR:   if (level > 0) level--;
            default: ;
        endcase
        if (fn <= FN_DUMP_BWD) sent++;
    endtask

    initial begin : stimulus
        int r;
        int target;
        bit first;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every pop and dump on an empty queue must report empty.
        send_word(FN_POP_FRONT, 32'h1234_5678);
        send_word(FN_POP_REAR, 32'hFFFF_FFFF);
        send_word(FN_DUMP_FWD, 32'd0);
        send_word(FN_DUMP_BWD, 32'h8000_0000);

        // A push at the front of an empty queue wraps the head below zero.
        send_word(FN_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(FN_PUSH_REAR, 32'h8000_0000);
        send_word(FN_PUSH_FRONT, 32'h0000_0000);
        send_word(FN_PUSH_REAR, 32'hFFFF_FFFF);
        send_word(FN_DUMP_FWD, 32'h5555_5555);
        send_word(FN_DUMP_BWD, 32'hAAAA_AAAA);

        // The spare function codes must leave the contents untouched.
        send_word(FN_SPARE_LO, 32'hDEAD_BEEF);
        send_word(FN_SPARE_HI, 32'h0BAD_F00D);

        // Drain from both ends; the fourth pop empties the queue, and the pop
        // and dump after it must see it empty.
        send_word(FN_POP_FRONT, 32'd0);
        send_word(FN_POP_REAR, 32'd0);
        send_word(FN_DUMP_FWD, 32'd0);
        send_word(FN_POP_REAR, 32'd0);
        send_word(FN_POP_FRONT, 32'd0);
        send_word(FN_POP_FRONT, 32'd0);
        send_word(FN_DUMP_BWD, 32'd0);

        // Random part, built from stretches. A fill stretch pushes until the
        // queue is full, overflows it and dumps the full contents; a drain
        // stretch pops it empty, underflows and dumps it; the rest are mixed
        // operations. The first stretch is always a fill so that the full
        // case is reached on every seed.
        target = sent + RANDOM_OPS;
        first  = 1'b1;
        while (sent < target) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (first || r < 2) begin
                while (level < DEPTH) begin
                    send_word($urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT,
                              pick_value());
                end
                repeat ($urandom_range(1, 2)) begin
                    send_word($urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT,
                              pick_value());
                end
                send_word($urandom_range(0, 1) ? FN_DUMP_BWD : FN_DUMP_FWD, pick_value());
            end else if (r < 4) begin
                while (level > 0) begin
                    send_word($urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT,
                              pick_value());
                end
                send_word($urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT, pick_value());
                send_word($urandom_range(0, 1) ? FN_DUMP_BWD : FN_DUMP_FWD, pick_value());
            end else begin
                repeat ($urandom_range(8, 20)) send_word(pick_mixed_op(), pick_value());
            end
            first = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        // Let every expected word arrive, then give the block a few more
        // cycles to show any stray word before the verdict.
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("PASS double_ended_queue");
        end else begin
            $display("FAIL double_ended_queue");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/deq_pkg.sv
hw/rtl/deq_dp.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue.sv
dv/double_ended_queue_check.sv
dv/double_ended_queue_test.sv
